### hw/rtl/ddsam_pkg.sv
// Shared constants, register codes and the sine-table math for the DDS AM/IQ modulator.
package ddsam_pkg;

  localparam int DEF_PHASE_BITS    = 32;
  localparam int DEF_LUT_ADDR_BITS = 10;
  localparam int DEF_SAMPLE_BITS   = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MODE_W      = 2;
  localparam int TUNING_W    = 32;
  localparam int POWER_W     = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TUNING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_CARRIER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AM      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IQ      = 2'd2;

  localparam logic [POWER_W-1:0] POWER_MAX = 7'd100;

  // pi/2 in Q30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor series of sin(x) in Q30, eight correction terms, clamped to one.
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    return sum;
  endfunction

endpackage

### hw/rtl/ddsam_sine_rom.sv
// Quarter-wave sine table with two registered read ports.
module ddsam_sine_rom
  import ddsam_pkg::*;
#(
  parameter int LUT_ADDR_BITS = DEF_LUT_ADDR_BITS,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [LUT_ADDR_BITS-1:0] sin_addr,
  input  logic [LUT_ADDR_BITS-1:0] cos_addr,
  output logic [SAMPLE_BITS-2:0]   sin_mag,
  output logic [SAMPLE_BITS-2:0]   cos_mag
);

  localparam int LUT_SIZE = 1 << LUT_ADDR_BITS;
  localparam int AMP_W    = SAMPLE_BITS - 1;

  typedef logic [AMP_W-1:0] rom_t [LUT_SIZE];

  // Entry k sits half a step past k, so no entry lands on a zero crossing.
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned x;
    longint unsigned s;
    longint unsigned v;
    longint unsigned amp;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k < LUT_SIZE; k++) begin
      x = ((longint'(2 * k + 1)) * HALF_PI_Q30 + (64'd1 << LUT_ADDR_BITS))
          >> (LUT_ADDR_BITS + 1);
      s = sin_q30(x);
      v = (s * amp + (64'd1 << 29)) >> 30;
      rom[k] = v[AMP_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sin_mag <= SINE_ROM[sin_addr];
      cos_mag <= SINE_ROM[cos_addr];
    end
  end

endmodule

### hw/rtl/ddsam_mult.sv
// Shared signed multiplier with a registered product.
module ddsam_mult #(
  parameter int MUL_W = 26
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_W-1:0]   op_a,
  input  logic signed [MUL_W-1:0]   op_b,
  output logic signed [2*MUL_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

### hw/rtl/dds_am_iq_modulator.sv
// DDS carrier source with carrier-only, AM and IQ modulation on one shared multiplier.
//
// Usage: each transaction on the input channel (sample_a, sample_b) yields exactly one
// transaction on the output channel (rf_sample). The carrier phase advances by
// tuning_word at every accepted input. Configuration writes go through cfg_write,
// cfg_index and cfg_data and must only happen while no item is in flight.
// After acceptance the sequencer runs ST_CP, ST_SP, ST_MA, ST_MB, ST_SUM, ST_RND,
// ST_DIV and ST_SAT, and out_valid rises as ST_SAT loads the result. The sequencer
// steps one multiplier through five passes (cos*P, sin*P, the modulation product,
// the IQ cross term and a reciprocal multiply that divides by 100), with add, round
// and saturation steps; in_stall is high from acceptance until the result is loaded.
// The result sits in an output register, so a new input is taken while it waits.
// If the receiver stalls, the finished item holds in the output register and the
// next item, once computed, waits in its final step until the register frees up.
// Reset (rst, synchronous) clears the phase accumulator, the configuration
// registers (mode carrier-only, tuning word 0, power 0) and the output valid.
module dds_am_iq_modulator
  import ddsam_pkg::*;
#(
  parameter int PHASE_BITS    = DEF_PHASE_BITS,
  parameter int LUT_ADDR_BITS = DEF_LUT_ADDR_BITS,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_a,
  input  logic signed [SAMPLE_BITS-1:0] sample_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] rf_sample
);

  localparam int S           = SAMPLE_BITS;
  localparam int MUL_W       = S + 10;
  localparam int CP_W        = S + 8;
  localparam int ACC_W       = 2 * S + 8;
  localparam int TW          = S + 8;
  localparam int RECIP_SHIFT = S + 15;
  localparam int RECIP_W     = S + 9;
  localparam int QW          = S + 2;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
  localparam logic [ACC_W-1:0] BIAS_CARRIER = ACC_W'(64'd50);
  localparam logic [ACC_W-1:0] BIAS_AM      = ACC_W'(64'd50 << (S + 1));
  localparam logic [ACC_W-1:0] BIAS_IQ      = ACC_W'(64'd50 << (S - 1));
  localparam logic [QW-1:0]    SAT_HI       = QW'((64'd1 << (S - 1)) - 64'd1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CP   = 9'b000000010,
    ST_SP   = 9'b000000100,
    ST_MA   = 9'b000001000,
    ST_MB   = 9'b000010000,
    ST_SUM  = 9'b000100000,
    ST_RND  = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_SAT  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [MODE_W-1:0]   mode;
  logic [TUNING_W-1:0] tuning_word;
  logic [POWER_W-1:0]  power_percent;
  logic [PHASE_BITS-1:0] phase_acc;

  logic [63:0]                  step_wide;
  logic [PHASE_BITS-1:0]        phase_step;
  logic [LUT_ADDR_BITS+1:0]     phase_top;
  logic [1:0]                   sin_quad;
  logic [1:0]                   cos_quad;
  logic [LUT_ADDR_BITS-1:0]     lut_idx;
  logic [LUT_ADDR_BITS-1:0]     sin_addr;
  logic [LUT_ADDR_BITS-1:0]     cos_addr;
  logic [S-2:0]                 sin_mag;
  logic [S-2:0]                 cos_mag;
  logic                         sin_neg;
  logic                         cos_neg;
  logic signed [S-1:0]          sin_val;
  logic signed [S-1:0]          cos_val;

  logic signed [S-1:0]          a_q;
  logic signed [S-1:0]          b_q;
  logic signed [CP_W-1:0]       cp_q;
  logic signed [CP_W-1:0]       sp_q;
  logic [ACC_W-1:0]             acc;
  logic                         neg_q;
  logic [TW-1:0]                t_q;

  logic                         accept;
  logic                         mul_en;
  logic signed [MUL_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]      mul_b;
  logic signed [2*MUL_W-1:0]    prod;

  logic                         acc_neg;
  logic [ACC_W-1:0]             rnd_sum;
  logic [ACC_W-1:0]             rnd_shift;
  logic [QW-1:0]                quo;
  logic [S-1:0]                 quo_lo;
  logic [S-1:0]                 result;
  logic                         load_out;

  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_CARRIER;
      tuning_word   <= '0;
      power_percent <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE: begin
          mode <= cfg_data[MODE_W-1:0];
        end
        REG_TUNING: begin
          tuning_word <= cfg_data[TUNING_W-1:0];
        end
        REG_POWER: begin
          if (cfg_data[POWER_W-1:0] <= POWER_MAX) begin
            power_percent <= cfg_data[POWER_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Phase accumulator and quarter-wave folding of the table address.
  assign step_wide  = {32'd0, tuning_word};
  assign phase_step = step_wide[PHASE_BITS-1:0];
  assign phase_top  = phase_acc[PHASE_BITS-1 -: LUT_ADDR_BITS + 2];
  assign sin_quad   = phase_top[LUT_ADDR_BITS+1:LUT_ADDR_BITS];
  assign cos_quad   = sin_quad + 2'd1;
  assign lut_idx    = phase_top[LUT_ADDR_BITS-1:0];
  assign sin_addr   = sin_quad[0] ? ~lut_idx : lut_idx;
  assign cos_addr   = cos_quad[0] ? ~lut_idx : lut_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept) begin
      phase_acc <= phase_acc + phase_step;
    end
  end

  ddsam_sine_rom #(
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_rom (
    .clk      (clk),
    .rd_en    (accept),
    .sin_addr (sin_addr),
    .cos_addr (cos_addr),
    .sin_mag  (sin_mag),
    .cos_mag  (cos_mag)
  );

  assign sin_val = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_CP: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(cos_val);
        mul_b  = MUL_W'({1'b0, power_percent});
      end
      ST_SP: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(sin_val);
        mul_b  = MUL_W'({1'b0, power_percent});
      end
      ST_MA: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(cp_q);
        // AM offsets the audio by one full scale, which flips its sign bit.
        if (mode == MODE_AM) begin
          mul_b = MUL_W'({1'b0, ~a_q[S-1], a_q[S-2:0]});
        end else if (mode == MODE_IQ) begin
          mul_b = MUL_W'(a_q);
        end else begin
          mul_b = MUL_W'(1);
        end
      end
      ST_MB: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(sp_q);
        mul_b  = MUL_W'(b_q);
      end
      ST_DIV: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'({1'b0, t_q});
        mul_b  = MUL_W'({1'b0, RECIP});
      end
      default: begin
      end
    endcase
  end

  ddsam_mult #(
    .MUL_W (MUL_W)
  ) u_mult (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Round half away from zero: the magnitude plus half the divisor, then the
  // power-of-two part of the divisor is shifted out.
  assign acc_neg = acc[ACC_W-1];

  always_comb begin
    rnd_sum   = '0;
    rnd_shift = '0;
    unique case (mode)
      MODE_AM: begin
        rnd_sum   = acc_neg ? (BIAS_AM - acc) : (acc + BIAS_AM);
        rnd_shift = rnd_sum >> (S + 1);
      end
      MODE_IQ: begin
        rnd_sum   = acc_neg ? (BIAS_IQ - acc) : (acc + BIAS_IQ);
        rnd_shift = rnd_sum >> (S - 1);
      end
      default: begin
        rnd_sum   = acc_neg ? (BIAS_CARRIER - acc) : (acc + BIAS_CARRIER);
        rnd_shift = rnd_sum;
      end
    endcase
  end

  // The reciprocal product gives the exact quotient by 100 for every rounded magnitude.
  assign quo    = prod[RECIP_SHIFT +: QW];
  assign quo_lo = quo[S-1:0];

  always_comb begin
    if (mode != MODE_CARRIER && mode != MODE_AM && mode != MODE_IQ) begin
      result = '0;
    end else if (!neg_q) begin
      result = (quo > SAT_HI) ? SAT_HI[S-1:0] : quo_lo;
    end else begin
      result = (quo > SAT_HI) ? {1'b1, {(S-1){1'b0}}} : ('0 - quo_lo);
    end
  end

  assign load_out = (state == ST_SAT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_CP;
      ST_CP:   state_next = ST_SP;
      ST_SP:   state_next = ST_MA;
      ST_MA:   state_next = ST_MB;
      ST_MB:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_RND;
      ST_RND:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_SAT;
      ST_SAT:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_q     <= sample_a;
      b_q     <= sample_b;
      sin_neg <= sin_quad[1];
      cos_neg <= cos_quad[1];
    end
    if (state == ST_SP) begin
      cp_q <= prod[CP_W-1:0];
    end
    if (state == ST_MA) begin
      sp_q <= prod[CP_W-1:0];
    end
    if (state == ST_MB) begin
      acc <= prod[ACC_W-1:0];
    end
    if (state == ST_SUM && mode == MODE_IQ) begin
      acc <= acc + prod[ACC_W-1:0];
    end
    if (state == ST_RND) begin
      neg_q <= acc_neg;
      t_q   <= rnd_shift[TW-1:0];
    end
    if (load_out) begin
      rf_sample <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### verif/dds_am_iq_modulator_tb.sv
// Self-checking testbench for the DDS carrier source with carrier, AM and IQ modulation.
module dds_am_iq_modulator_tb;
  import ddsam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = DEF_SAMPLE_BITS;
  localparam int FRAC_W     = SAMPLE_W - 1;
  localparam int LUT_W      = DEF_LUT_ADDR_BITS;
  localparam int LUT_DEPTH  = 1 << LUT_W;
  localparam int PHASE_W    = DEF_PHASE_BITS;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0]      MODE_OFF   = 2'd3;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
  } baseband_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sample_t                sample_a = '0;
  sample_t                sample_b = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sample_t                rf_sample;

  dds_am_iq_modulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_a  (sample_a),
    .sample_b  (sample_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rf_sample (rf_sample)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the modulator state and its registers.
  logic [MODE_W-1:0]   mode_cfg = MODE_CARRIER;
  logic [TUNING_W-1:0] tuning_cfg = '0;
  logic [POWER_W-1:0]  power_cfg = '0;
  logic [PHASE_W-1:0]  carrier_phase = '0;
  int                  quarter_sine [LUT_DEPTH];

  baseband_t pending_pairs [$];
  sample_t   rf_expected_q [$];
  baseband_t launch_item;

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int items_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int items_per_mode [4] = '{default: 0};

  function automatic longint unsigned taylor_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    return sum;
  endfunction

  // Entries sit half a step off the grid, so no entry lands on a zero crossing.
  function automatic void fill_quarter_sine();
    longint unsigned amp;
    longint unsigned x;
    longint unsigned s;
    amp = (64'd1 << FRAC_W) - 1;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      x = ((2 * longint'(k) + 1) * HALF_PI_Q30 + (64'd1 << LUT_W)) >> (LUT_W + 1);
      s = taylor_sine(x);
      quarter_sine[k] = int'((s * amp + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic longint carrier_wave(input logic [1:0] quad, input logic [LUT_W-1:0] idx);
    logic [LUT_W-1:0] j;
    j = quad[0] ? ~idx : idx;
    return quad[1] ? -longint'(quarter_sine[j]) : longint'(quarter_sine[j]);
  endfunction

  // Scales by power percent over 100 * 2^shift, rounds half away from zero, saturates.
  function automatic sample_t scale_by_power(input longint prod, input int shift);
    longint          num;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned quo;
    logic [SAMPLE_W-1:0] r;
    num = prod * longint'(power_cfg);
    den = 64'd100 << shift;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    if (num < 0) begin
      if (quo > (64'd1 << FRAC_W)) begin
        quo = 64'd1 << FRAC_W;
      end
      r = quo[SAMPLE_W-1:0];
      return -r;
    end
    if (quo > (64'd1 << FRAC_W) - 1) begin
      quo = (64'd1 << FRAC_W) - 1;
    end
    return quo[SAMPLE_W-1:0];
  endfunction

  function automatic sample_t modulate(input sample_t a_in, input sample_t b_in);
    logic [1:0]       quad;
    logic [LUT_W-1:0] idx;
    longint           c;
    longint           s;
    longint           a;
    longint           b;
    quad = carrier_phase[PHASE_W-1 -: 2];
    idx  = carrier_phase[PHASE_W-3 -: LUT_W];
    s    = carrier_wave(quad, idx);
    c    = carrier_wave(quad + 2'd1, idx);
    a    = a_in;
    b    = b_in;
    case (mode_cfg)
      MODE_CARRIER: return scale_by_power(c, 0);
      MODE_AM:      return scale_by_power(c * (a + (64'sd1 <<< FRAC_W)), FRAC_W + 2);
      MODE_IQ:      return scale_by_power(c * a + s * b, FRAC_W);
      default:      return '0;
    endcase
  endfunction

  function automatic int draw_gap(input int pct);
    if (!idle_on || $urandom_range(0, 99) >= pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 6);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 27))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return '0;
      3:       return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string line);
    $display("[%0t] MISMATCH %s", $realtime, line);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MODE:   mode_cfg = data[MODE_W-1:0];
      REG_TUNING: tuning_cfg = data[TUNING_W-1:0];
      REG_POWER: begin
        // Out-of-range power is dropped and the old value stays.
        if (data[POWER_W-1:0] <= POWER_MAX) begin
          power_cfg = data[POWER_W-1:0];
        end
      end
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_pair(input sample_t a, input sample_t b);
    pending_pairs.push_back('{a: a, b: b});
    items_queued++;
  endtask

  task automatic settle();
    while (results_seen < items_queued) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input side: launches queued pairs and predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rf_expected_q.push_back(modulate(sample_a, sample_b));
        items_per_mode[mode_cfg]++;
        carrier_phase = carrier_phase + PHASE_W'(tuning_cfg);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          launch_item = pending_pairs.pop_front();
          sample_a <= launch_item.a;
          sample_b <= launch_item.b;
          in_valid <= 1'b1;
          send_gap = draw_gap(35);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each result and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (rf_expected_q.size() == 0) begin
          report_mismatch($sformatf("rf_sample %0d with no transaction outstanding", rf_sample));
        end else if (rf_sample !== rf_expected_q[0]) begin
          report_mismatch($sformatf("rf_sample got %0d want %0d", rf_sample, rf_expected_q[0]));
          void'(rf_expected_q.pop_front());
        end else begin
          void'(rf_expected_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = draw_gap(15);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, items_queued);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                    random_items;
    int                    n_items;
    int                    roll;
    logic [CFG_DATA_W-1:0] word;
    logic [POWER_W-1:0]    pct;

    random_items = 0;
    fill_quarter_sine();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values: zero power gives a silent output.
    push_pair(sample_t'(32767), sample_t'(-32768));
    push_pair(sample_t'(-32768), sample_t'(32767));
    settle();

    // Quarter-turn steps visit all four quadrants of the carrier.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_CARRIER));
    write_reg(REG_TUNING, 32'h4000_0000);
    write_reg(REG_POWER, CFG_DATA_W'(POWER_MAX));
    push_pair('0, '0);
    push_pair(sample_t'(32767), sample_t'(32767));
    push_pair(sample_t'(-32768), sample_t'(-32768));
    push_pair('1, sample_t'(1));
    settle();

    // AM with the audio sample at both extremes and at zero.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_AM));
    write_reg(REG_TUNING, 32'h0010_0000);
    push_pair(sample_t'(-32768), '0);
    push_pair(sample_t'(32767), '1);
    push_pair('0, sample_t'(32767));
    push_pair('1, sample_t'(-32768));
    push_pair(sample_t'(16384), '0);
    settle();

    // IQ at 45 degree steps, where I and Q together overflow and saturate.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_IQ));
    write_reg(REG_TUNING, 32'h2000_0000);
    push_pair(sample_t'(32767), sample_t'(32767));
    push_pair(sample_t'(-32768), sample_t'(-32768));
    push_pair(sample_t'(32767), sample_t'(-32768));
    push_pair(sample_t'(-32768), sample_t'(32767));
    push_pair('0, '0);
    push_pair(sample_t'(12345), sample_t'(-12345));
    settle();

    // Unused mode code silences the output while the phase still moves; a power
    // above 100 and a write to the unused index are both dropped.
    write_reg(REG_MODE, 32'hFFFF_FFFF);
    write_reg(REG_TUNING, 32'hFFFF_FFFF);
    write_reg(REG_POWER, 32'd101);
    write_reg(REG_UNUSED, 32'hA5A5_A5A5);
    push_pair(sample_t'(32767), sample_t'(32767));
    push_pair(sample_t'(-32768), '0);
    push_pair('1, '1);
    settle();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_IQ));
    write_reg(REG_TUNING, 32'h8000_0000);
    write_reg(REG_POWER, 32'd1);
    push_pair(sample_t'(32767), sample_t'(-32768));
    push_pair(sample_t'(-32768), sample_t'(32767));
    push_pair(sample_t'(20000), sample_t'(-7));
    settle();

    while (random_items < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);

      roll = $urandom_range(0, 19);
      word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
      if (roll < 3) begin
        word[MODE_W-1:0] = MODE_CARRIER;
      end else if (roll < 10) begin
        word[MODE_W-1:0] = MODE_AM;
      end else if (roll < 18) begin
        word[MODE_W-1:0] = MODE_IQ;
      end else begin
        word[MODE_W-1:0] = MODE_OFF;
      end
      write_reg(REG_MODE, word);

      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       word = '0;
          1:       word = 32'hFFFF_FFFF;
          2, 3:    word = $urandom_range(1, 32'h00FF_FFFF);
          default: word = $urandom();
        endcase
        write_reg(REG_TUNING, word);
      end

      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       pct = POWER_MAX;
          1:       pct = POWER_W'($urandom_range(101, 127));
          2:       pct = '0;
          default: pct = POWER_W'($urandom_range(0, 100));
        endcase
        word = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom()) : '0;
        word[POWER_W-1:0] = pct;
        write_reg(REG_POWER, word);
      end

      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_UNUSED, $urandom());
      end

      n_items = $urandom_range(60, 190);
      for (int i = 0; i < n_items; i++) begin
        push_pair(draw_sample(), draw_sample());
      end
      random_items += n_items;
      settle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d transactions: carrier %0d, AM %0d, IQ %0d, unused mode %0d",
             items_sent, items_per_mode[MODE_CARRIER], items_per_mode[MODE_AM],
             items_per_mode[MODE_IQ], items_per_mode[MODE_OFF]);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             reg_writes, results_seen, mismatch_count);
    if (mismatch_count == 0 && rf_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
